// ===== hw/rtl/jsu_pkg.sv =====
package jsu_pkg;

    // Result status codes
    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_BADESC = 3'd2;
    localparam logic [2:0] ST_BADHEX = 3'd3;
    localparam logic [2:0] ST_BADSUR = 3'd4;
    localparam logic [2:0] ST_UNTERM = 3'd5;
    localparam logic [2:0] ST_NOOPEN = 3'd6;

    // Work for one input beat: 0..4 decoded bytes, then an optional status beat.
    typedef struct packed {
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            has_stat;
        logic [2:0]      stat;
    } t_entry;

endpackage

// ===== hw/rtl/jsu_front.sv =====
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic             i_text_end,
    output jsu_pkg::t_entry  o_entry,
    output logic             o_push
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_BODY = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_HEX  = 3'd3;
    localparam logic [2:0] M_SBS  = 3'd4;
    localparam logic [2:0] M_SU   = 3'd5;
    localparam logic [2:0] M_LHEX = 3'd6;
    localparam logic [2:0] M_DROP = 3'd7;

    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_hi, n_hi;

    logic [3:0]  hex_v;
    logic        hex_ok;
    logic [15:0] acc_sh;
    logic [20:0] cp;
    logic        do_utf8;
    jsu_pkg::t_entry ent;

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_v = i_in_byte[3:0];
        end else if ((i_in_byte >= 8'h61 && i_in_byte <= 8'h66) ||
                     (i_in_byte >= 8'h41 && i_in_byte <= 8'h46)) begin
            hex_v = i_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_sh = {r_acc[11:0], hex_v};

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_hi    = r_hi;
        ent     = '0;
        do_utf8 = 1'b0;
        cp      = '0;
        unique case (r_mode)
            M_IDLE: begin
                if (i_in_byte == 8'h22) begin
                    n_mode = M_BODY;
                end else begin
                    ent.has_stat = 1'b1;
                    ent.stat     = jsu_pkg::ST_NOOPEN;
                    n_mode       = M_DROP;
                end
            end
            M_BODY: begin
                if (i_in_byte == 8'h22) begin
                    ent.has_stat = 1'b1;
                    ent.stat     = jsu_pkg::ST_DONE;
                    n_mode       = M_IDLE;
                end else if (i_in_byte == 8'h5C) begin
                    n_mode = M_ESC;
                end else begin
                    ent.nbytes   = 3'd1;
                    ent.bytes[0] = i_in_byte;
                end
            end
            M_ESC: begin
                n_mode     = M_BODY;
                ent.nbytes = 3'd1;
                unique case (i_in_byte)
                    8'h22, 8'h5C, 8'h2F: ent.bytes[0] = i_in_byte;
                    8'h62: ent.bytes[0] = 8'h08;
                    8'h66: ent.bytes[0] = 8'h0C;
                    8'h6E: ent.bytes[0] = 8'h0A;
                    8'h72: ent.bytes[0] = 8'h0D;
                    8'h74: ent.bytes[0] = 8'h09;
                    8'h75: begin
                        ent.nbytes = 3'd0;
                        n_acc      = '0;
                        n_cnt      = '0;
                        n_mode     = M_HEX;
                    end
                    default: begin
                        ent.nbytes   = 3'd0;
                        ent.has_stat = 1'b1;
                        ent.stat     = jsu_pkg::ST_BADESC;
                        n_mode       = M_DROP;
                    end
                endcase
            end
            M_HEX, M_LHEX: begin
                if (!hex_ok) begin
                    ent.has_stat = 1'b1;
                    ent.stat     = jsu_pkg::ST_BADHEX;
                    n_mode       = M_DROP;
                end else begin
                    n_acc = acc_sh;
                    if (r_cnt == 2'd3) begin
                        n_cnt = 2'd0;
                        if (r_mode == M_HEX) begin
                            if (acc_sh[15:10] == 6'b110110) begin
                                n_hi   = acc_sh;
                                n_mode = M_SBS;
                            end else begin
                                do_utf8 = 1'b1;
                                cp      = {5'd0, acc_sh};
                                n_mode  = M_BODY;
                            end
                        end else if (acc_sh[15:10] != 6'b110111) begin
                            ent.has_stat = 1'b1;
                            ent.stat     = jsu_pkg::ST_BADSUR;
                            n_mode       = M_DROP;
                        end else begin
                            // pair: 0x10000 + high[9:0]:low[9:0]
                            do_utf8 = 1'b1;
                            cp      = 21'h10000 + {1'b0, r_hi[9:0], acc_sh[9:0]};
                            n_mode  = M_BODY;
                        end
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            M_SBS: begin
                if (i_in_byte == 8'h5C) begin
                    n_mode = M_SU;
                end else begin
                    ent.has_stat = 1'b1;
                    ent.stat     = jsu_pkg::ST_BADSUR;
                    n_mode       = M_DROP;
                end
            end
            M_SU: begin
                if (i_in_byte == 8'h75) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_mode = M_LHEX;
                end else begin
                    ent.has_stat = 1'b1;
                    ent.stat     = jsu_pkg::ST_BADSUR;
                    n_mode       = M_DROP;
                end
            end
            M_DROP: begin
            end
            default: n_mode = M_DROP;
        endcase

        // UTF-8 encode
        if (do_utf8) begin
            if (cp <= 21'h7F) begin
                ent.nbytes   = 3'd1;
                ent.bytes[0] = cp[7:0];
            end else if (cp <= 21'h7FF) begin
                ent.nbytes   = 3'd2;
                ent.bytes[0] = {3'b110, cp[10:6]};
                ent.bytes[1] = {2'b10, cp[5:0]};
            end else if (cp <= 21'hFFFF) begin
                ent.nbytes   = 3'd3;
                ent.bytes[0] = {4'b1110, cp[15:12]};
                ent.bytes[1] = {2'b10, cp[11:6]};
                ent.bytes[2] = {2'b10, cp[5:0]};
            end else begin
                ent.nbytes   = 3'd4;
                ent.bytes[0] = {5'b11110, cp[20:18]};
                ent.bytes[1] = {2'b10, cp[17:12]};
                ent.bytes[2] = {2'b10, cp[11:6]};
                ent.bytes[3] = {2'b10, cp[5:0]};
            end
        end

        // end of text: flag an open string, then back to reset state
        if (i_text_end) begin
            if (n_mode != M_IDLE && n_mode != M_DROP) begin
                ent.has_stat = 1'b1;
                ent.stat     = jsu_pkg::ST_UNTERM;
            end
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_acc  = '0;
            n_hi   = '0;
        end
    end

    assign o_entry = ent;
    assign o_push  = i_accept && (ent.nbytes != 3'd0 || ent.has_stat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_hi   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_hi   <= n_hi;
        end
    end

endmodule

// ===== hw/rtl/jsu_fifo.sv =====
module jsu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_entry  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output jsu_pkg::t_entry  o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    jsu_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULLC);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/jsu_back.sv =====
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jsu_pkg::t_entry  i_data,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_status,
    output logic             o_run_last
);

    jsu_pkg::t_entry r_cur;
    logic        r_busy;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic [2:0]  r_ostat;
    logic        r_olast;

    logic is_byte, cur_last, load;

    assign is_byte  = (r_idx < r_cur.nbytes);
    assign cur_last = r_cur.has_stat ? (r_idx == r_cur.nbytes)
                                     : (r_idx == r_cur.nbytes - 3'd1);
    assign load     = r_busy && (!r_ovalid || i_out_ready);
    assign o_pop    = !i_empty && (!r_busy || (load && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_idx    <= r_idx + 3'd1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (load && cur_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
        if (load) begin
            r_obyte <= is_byte ? r_cur.bytes[r_idx[1:0]] : 8'd0;
            r_ostat <= is_byte ? jsu_pkg::ST_BYTE : r_cur.stat;
            r_olast <= cur_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_status    = r_ostat;
    assign o_run_last  = r_olast;

endmodule

// ===== hw/rtl/json_string_unescape_utf8_core.sv =====
// Path: each entry is queued, popped into the serializer, then sent beat by beat.
// Throughput: one input beat per cycle while the entry queue has room; results leave
//   at one beat per cycle while the receiver is ready, so a \u escape (up to 4 bytes)
//   holds input back only once the QDEPTH-entry queue between decoder and serializer fills.
// Reset: i_rst_n synchronous, active low; decoder returns to idle, queue and output empty.
module json_string_unescape_utf8_core #(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_run_last
);

    jsu_pkg::t_entry push_entry, head_entry;
    logic accept, push, full, empty, pop;

    // Input is taken whenever the queue can hold one more entry; the decoder
    // classifies each beat and pushes the results it causes as one entry.
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .o_entry    (push_entry),
        .o_push     (push)
    );

    // Short queue: decoder and serializer stall independently.
    jsu_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (empty)
    );

    // Serializer: one result beat per cycle into the output register while the receiver is ready.
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (head_entry),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== dv/json_string_unescape_utf8_core_tb.sv =====
module json_string_unescape_utf8_core_tb;

    // Character codes that steer the decoder
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // Decoder modes of the predictor
    typedef enum logic [3:0] {
        DM_IDLE,
        DM_BODY,
        DM_ESC,
        DM_HEX,
        DM_SBS,
        DM_SU,
        DM_LHEX,
        DM_DROP
    } t_dec_mode;

    // One expected result beat
    typedef struct {
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } t_dec_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_text_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;
    logic       o_run_last;

    json_string_unescape_utf8_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_text_end  (i_text_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    t_dec_mode   dec_mode;
    logic [1:0]  hex_cnt;
    logic [15:0] hex_acc;
    logic [15:0] hi_sur;

    t_dec_beat   step_q[$];     // results of the beat being predicted
    t_dec_beat   decoded_q[$];  // results still owed by the block
    logic [7:0]  text_q[$];     // bytes of the text being built

    int snd_idle_pct;
    int rcv_idle_pct;
    int live_beats;             // accepted beats the decoder did not drop
    int n_fail;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_decoder();
        dec_mode = DM_IDLE;
        hex_cnt  = 2'd0;
        hex_acc  = 16'h0000;
        hi_sur   = 16'h0000;
    endfunction

    function automatic void emit_beat(input logic [2:0] st, input logic [7:0] b);
        t_dec_beat r;
        if (step_q.size() < 5) begin
            r.data   = (st == jsu_pkg::ST_BYTE) ? b : 8'h00;
            r.status = st;
            r.last   = 1'b0;
            step_q   = {step_q, r};
        end
    endfunction

    // UTF-8 encode one code point, 1 to 4 bytes
    function automatic void emit_cp(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit_beat(jsu_pkg::ST_BYTE, cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            emit_beat(jsu_pkg::ST_BYTE, {3'b110, cp[10:6]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            emit_beat(jsu_pkg::ST_BYTE, {4'b1110, cp[15:12]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[11:6]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[5:0]});
        end else begin
            emit_beat(jsu_pkg::ST_BYTE, {5'b11110, cp[20:18]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[17:12]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[11:6]});
            emit_beat(jsu_pkg::ST_BYTE, {2'b10, cp[5:0]});
        end
    endfunction

    function automatic void to_drop(input logic [2:0] st);
        emit_beat(st, 8'h00);
        dec_mode = DM_DROP;
    endfunction

    // Value of a hex digit, 16 when not one
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return 5'd16;
    endfunction

    // Shift in one digit; 1 once the fourth is in
    function automatic logic shift_digit(input logic [3:0] v);
        hex_acc = {hex_acc[11:0], v};
        if (hex_cnt == 2'd3) begin
            hex_cnt = 2'd0;
            return 1'b1;
        end
        hex_cnt = hex_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic e);
        logic [4:0]  v;
        logic [20:0] cp;
        step_q.delete();
        case (dec_mode)
            DM_IDLE: begin
                if (b == CH_QUOTE) dec_mode = DM_BODY;
                else to_drop(jsu_pkg::ST_NOOPEN);
            end
            DM_BODY: begin
                if (b == CH_QUOTE) begin
                    emit_beat(jsu_pkg::ST_DONE, 8'h00);
                    dec_mode = DM_IDLE;
                end else if (b == CH_BSLASH) begin
                    dec_mode = DM_ESC;
                end else begin
                    emit_beat(jsu_pkg::ST_BYTE, b);
                end
            end
            DM_ESC: begin
                dec_mode = DM_BODY;
                case (b)
                    8'h22: emit_beat(jsu_pkg::ST_BYTE, 8'h22);
                    8'h5C: emit_beat(jsu_pkg::ST_BYTE, 8'h5C);
                    8'h2F: emit_beat(jsu_pkg::ST_BYTE, 8'h2F);
                    8'h62: emit_beat(jsu_pkg::ST_BYTE, 8'h08);
                    8'h66: emit_beat(jsu_pkg::ST_BYTE, 8'h0C);
                    8'h6E: emit_beat(jsu_pkg::ST_BYTE, 8'h0A);
                    8'h72: emit_beat(jsu_pkg::ST_BYTE, 8'h0D);
                    8'h74: emit_beat(jsu_pkg::ST_BYTE, 8'h09);
                    CH_U: begin
                        hex_acc  = 16'h0000;
                        hex_cnt  = 2'd0;
                        dec_mode = DM_HEX;
                    end
                    default: to_drop(jsu_pkg::ST_BADESC);
                endcase
            end
            DM_HEX: begin
                v = hex_nibble(b);
                if (v[4]) begin
                    to_drop(jsu_pkg::ST_BADHEX);
                end else if (shift_digit(v[3:0])) begin
                    if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                        hi_sur   = hex_acc;
                        dec_mode = DM_SBS;
                    end else begin
                        emit_cp({5'd0, hex_acc});
                        dec_mode = DM_BODY;
                    end
                end
            end
            DM_SBS: begin
                if (b == CH_BSLASH) dec_mode = DM_SU;
                else to_drop(jsu_pkg::ST_BADSUR);
            end
            DM_SU: begin
                if (b == CH_U) begin
                    hex_acc  = 16'h0000;
                    hex_cnt  = 2'd0;
                    dec_mode = DM_LHEX;
                end else begin
                    to_drop(jsu_pkg::ST_BADSUR);
                end
            end
            DM_LHEX: begin
                v = hex_nibble(b);
                if (v[4]) begin
                    to_drop(jsu_pkg::ST_BADHEX);
                end else if (shift_digit(v[3:0])) begin
                    if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                        to_drop(jsu_pkg::ST_BADSUR);
                    end else begin
                        // high and low halves each carry 10 bits above 0x10000
                        cp = 21'h10000 + {1'b0, hi_sur[9:0], hex_acc[9:0]};
                        emit_cp(cp);
                        dec_mode = DM_BODY;
                    end
                end
            end
            default: ;  // dropping
        endcase
        if (e) begin
            if (dec_mode != DM_IDLE && dec_mode != DM_DROP)
                emit_beat(jsu_pkg::ST_UNTERM, 8'h00);
            reset_decoder();
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        decoded_q = {decoded_q, step_q};
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat per call, random gaps before it
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_text_end <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (dec_mode != DM_DROP) live_beats++;
        predict_beat(b, e);
    endtask

    // Send the built text, text end on the last byte if asked
    task automatic send_text(input logic with_end);
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], with_end && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    // Input goes idle, then wait until every owed beat has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : chk
        t_dec_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result beat: status %0d, out_byte %02h", o_status, o_out_byte);
                n_fail++;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, actual %02h", want.data, o_out_byte);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    n_fail++;
                end
                if (o_run_last !== want.last) begin
                    $error("run_last: expected %0d, actual %0d", want.last, o_run_last);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Text builders
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + v;
        return ($urandom_range(1) ? "a" : "A") + v - 4'd10;
    endfunction

    // \u escape with four digits in mixed case
    function automatic void add_u(input logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function automatic logic is_esc_char(input logic [7:0] c);
        return c == 8'h22 || c == 8'h5C || c == 8'h2F || c == 8'h62 || c == 8'h66 ||
               c == 8'h6E || c == 8'h72 || c == 8'h74 || c == CH_U;
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    // One element of string content: plain byte, escape, or a broken escape
    function automatic void add_element();
        logic [7:0]  c;
        logic [7:0]  esc_tab[8];
        logic [15:0] cp;
        int          kind;
        int          k;
        esc_tab = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
        kind = $urandom_range(99);
        if (kind < 40) begin
            do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
            add_byte(c);
        end else if (kind < 58) begin
            add_byte(CH_BSLASH);
            add_byte(esc_tab[$urandom_range(7)]);
        end else if (kind < 74) begin
            case ($urandom_range(3))
                0: cp = 16'($urandom_range(16'h7F));
                1: cp = 16'($urandom_range(16'h80, 16'h7FF));
                2: do cp = 16'($urandom_range(16'h800, 16'hFFFF));
                   while (cp >= 16'hD800 && cp <= 16'hDBFF);
                default: cp = 16'($urandom_range(16'hDC00, 16'hDFFF));  // lone low half
            endcase
            add_u(cp);
        end else if (kind < 87) begin
            add_u(rand_high());
            add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else begin
            case ($urandom_range(5))
                0: begin  // unknown escape letter
                    add_byte(CH_BSLASH);
                    do c = 8'($urandom_range(255)); while (is_esc_char(c));
                    add_byte(c);
                end
                1: begin  // bad digit somewhere in \uXXXX
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    k = $urandom_range(3);
                    repeat (k) add_byte(hex_char(4'($urandom_range(15))));
                    do c = 8'($urandom_range(255)); while (hex_nibble(c) != 5'd16);
                    add_byte(c);
                end
                2: begin  // high half not followed by backslash
                    add_u(rand_high());
                    do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
                    add_byte(c);
                end
                3: begin  // high half, backslash, then not u
                    add_u(rand_high());
                    add_byte(CH_BSLASH);
                    do c = 8'($urandom_range(255)); while (c == CH_U);
                    add_byte(c);
                end
                4: begin  // second half outside the low range
                    add_u(rand_high());
                    do cp = 16'($urandom_range(16'hFFFF));
                    while (cp >= 16'hDC00 && cp <= 16'hDFFF);
                    add_u(cp);
                end
                default: begin  // bad digit in the low half
                    add_u(rand_high());
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    do c = 8'($urandom_range(255)); while (hex_nibble(c) != 5'd16);
                    add_byte(c);
                end
            endcase
        end
    endfunction

    // Mostly well-formed strings; some noise, cut-offs and missing quotes
    task automatic send_random_text();
        int k;
        if ($urandom_range(99) < 8) begin
            k = $urandom_range(1, 4);
            repeat (k) add_byte(8'($urandom_range(255)));
            send_text(1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6)) add_element();
                if ($urandom_range(99) < 90) add_byte(CH_QUOTE);
            end
            // cut the text short, often inside an escape
            if ($urandom_range(99) < 12) begin
                k = $urandom_range(1, text_q.size() - 1);
                while (text_q.size() > k) void'(text_q.pop_back());
            end
            send_text($urandom_range(99) < 90);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // First byte not a quote, then text end while dropping
    task automatic test_no_open_quote();
        add_byte(8'h00);
        add_byte(8'hFF);
        send_text(1'b1);
    endtask

    // Plain byte at the top of the range, an escape, a bad escape on the last byte
    task automatic test_bad_escape_on_end();
        add_str("\"");
        add_byte(8'hFF);
        add_str("\\n\\z");
        send_text(1'b1);
    endtask

    // Largest code point through a pair, lower case low half, closing quote on end
    task automatic test_surrogate_pair();
        add_str("\"\\uDBFF\\udfff\"");
        send_text(1'b1);
    endtask

    // Bad hex digit on the final byte stands alone
    task automatic test_bad_hex_on_end();
        add_str("\"\\ug");
        send_text(1'b1);
    endtask

    // Text ends inside the body
    task automatic test_unterminated();
        add_str("\"a");
        send_text(1'b1);
    endtask

    task automatic test_random_texts(input int snd_pct, input int rcv_pct, input int n_live);
        int target;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        target = live_beats + n_live;
        while (live_beats < target) send_random_text();
    endtask

    // Sender holds off until the block has delivered everything owed
    task automatic test_drain_pause();
        send_random_text();
        wait_drained();
        send_random_text();
        wait_drained();
        send_random_text();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_byte    = 8'h00;
        i_text_end   = 1'b0;
        i_out_ready  = 1'b0;
        snd_idle_pct = 16;
        rcv_idle_pct = 55;
        live_beats   = 0;
        n_fail       = 0;
        reset_decoder();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_open_quote();
        test_bad_escape_on_end();
        test_surrogate_pair();
        test_bad_hex_on_end();
        test_unterminated();

        test_random_texts(16, 55, 130);
        test_drain_pause();
        test_random_texts(55, 16, 130);
        test_random_texts(0, 0, 130);

        wait_drained();
        // keep clocking after the drain to catch stray beats
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && decoded_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #3200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
